// ----- sv/nps_pkg.sv -----
// Shared types, microcode encoding and control store for the priority scheduler.
package nps_pkg;

  localparam int STEP_W = 4;
  localparam int TIME_W = 23;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int PIDX_W = 6;
  localparam int REC_W  = ARR_W + BUR_W + PRI_W;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_LOAD       = 4'd0;
  localparam step_t S_INIT       = 4'd1;
  localparam step_t S_SCAN_START = 4'd2;
  localparam step_t S_SCAN_RD    = 4'd3;
  localparam step_t S_SCAN_EVAL  = 4'd4;
  localparam step_t S_DECIDE     = 4'd5;
  localparam step_t S_EMIT_START = 4'd6;
  localparam step_t S_EMIT_RD    = 4'd7;
  localparam step_t S_EMIT_OUT   = 4'd8;
  localparam step_t S_EMIT_NEXT  = 4'd9;
  localparam step_t S_FINISH     = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_SCAN_START,
    OP_SCAN_RD,
    OP_SCAN_EVAL,
    OP_DECIDE,
    OP_EMIT_START,
    OP_EMIT_RD,
    OP_EMIT_OUT,
    OP_EMIT_NEXT,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LAST,
    C_MORE,
    C_SCHED_OPEN,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic last_in;
    logic more;
    logic sched_open;
    logic out_blocked;
  } status_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    unique case (step)
      S_LOAD:       w = '{OP_LOAD,       C_NOT_LAST,    S_LOAD};
      S_INIT:       w = '{OP_INIT,       C_NEVER,       S_LOAD};
      S_SCAN_START: w = '{OP_SCAN_START, C_NEVER,       S_LOAD};
      S_SCAN_RD:    w = '{OP_SCAN_RD,    C_NEVER,       S_LOAD};
      S_SCAN_EVAL:  w = '{OP_SCAN_EVAL,  C_MORE,        S_SCAN_RD};
      S_DECIDE:     w = '{OP_DECIDE,     C_SCHED_OPEN,  S_SCAN_START};
      S_EMIT_START: w = '{OP_EMIT_START, C_NEVER,       S_LOAD};
      S_EMIT_RD:    w = '{OP_EMIT_RD,    C_NEVER,       S_LOAD};
      S_EMIT_OUT:   w = '{OP_EMIT_OUT,   C_OUT_BLOCKED, S_EMIT_OUT};
      S_EMIT_NEXT:  w = '{OP_EMIT_NEXT,  C_MORE,        S_EMIT_RD};
      S_FINISH:     w = '{OP_FINISH,     C_ALWAYS,      S_LOAD};
      default:      w = '{OP_NOP,        C_ALWAYS,      S_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/nonpreemptive_priority_scheduler.sv -----
// Top level: non-preemptive priority scheduler built on a microcoded sequencer.
// Loading accepts one record per cycle while in_valid is high; results appear only after the
// record with last_process. Scheduling: n decisions, each a scan through the record RAM read
// port, plus idle-time jumps. Emitting reads each result, holding it while out_ready is low.
// rst is synchronous: it clears the step counter, record count, done flags, time and out_valid.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [nps_pkg::ARR_W-1:0]    arrival_time,
  input  logic [nps_pkg::BUR_W-1:0]    burst_time,
  input  logic [nps_pkg::PRI_W-1:0]    priority_level,
  input  logic                         last_process,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nps_pkg::PIDX_W-1:0]   process_index,
  output logic [nps_pkg::TIME_W-1:0]   completion_time,
  output logic [nps_pkg::TIME_W-1:0]   turnaround_time,
  output logic [nps_pkg::TIME_W-1:0]   waiting_time,
  output logic                         last_result
);
  import nps_pkg::*;

  ctrl_word_t ctrl;
  status_t    status;

  nps_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  nps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .status          (status),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .priority_level  (priority_level),
    .last_process    (last_process),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .process_index   (process_index),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .last_result     (last_result)
  );

endmodule

// ----- sv/nps_ram.sv -----
// Generic simple dual-port RAM with registered read.
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/nps_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module nps_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  nps_pkg::status_t    status,
  output nps_pkg::ctrl_word_t ctrl
);
  import nps_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  take;

  assign ctrl = ucode_rom(pc);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NOT_LAST:    take = !status.last_in;
      C_MORE:        take = status.more;
      C_SCHED_OPEN:  take = status.sched_open;
      C_OUT_BLOCKED: take = status.out_blocked;
      default:       take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- sv/nps_datapath.sv -----
// Datapath: record and completion stores, scan registers, time keeping, result register.
module nps_datapath #(
  parameter int MAX_PROCS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nps_pkg::ctrl_word_t                  ctrl,
  output nps_pkg::status_t                     status,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [nps_pkg::ARR_W-1:0]            arrival_time,
  input  logic [nps_pkg::BUR_W-1:0]            burst_time,
  input  logic [nps_pkg::PRI_W-1:0]            priority_level,
  input  logic                                 last_process,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nps_pkg::PIDX_W-1:0]           process_index,
  output logic [nps_pkg::TIME_W-1:0]           completion_time,
  output logic [nps_pkg::TIME_W-1:0]           turnaround_time,
  output logic [nps_pkg::TIME_W-1:0]           waiting_time,
  output logic                                 last_result
);
  import nps_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     finished;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     pick;
  logic [MAX_PROCS-1:0] done;
  logic [TIME_W-1:0]    cur_time;
  logic [PRI_W:0]       best;
  logic [ARR_W:0]       next_arr;
  logic [BUR_W-1:0]     burst_best;
  logic                 found;

  logic                 in_acc;
  logic                 rec_we;
  logic                 rec_re;
  logic [REC_W-1:0]     rec_wdata;
  logic [REC_W-1:0]     rec_rdata;
  logic [IDX_W-1:0]     rec_raddr;
  logic [ARR_W-1:0]     rd_arr;
  logic [BUR_W-1:0]     rd_bur;
  logic [PRI_W-1:0]     rd_pri;
  logic                 comp_we;
  logic                 comp_re;
  logic [TIME_W-1:0]    comp_rdata;
  logic [TIME_W-1:0]    time_sum;
  logic [TIME_W-1:0]    tat;
  logic [CNT_W-1:0]     idx_plus;
  logic                 emit_load;

  assign in_ready  = (ctrl.op == OP_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign rec_we    = in_acc && (count < CNT_W'(MAX_PROCS));
  assign rec_wdata = {arrival_time, burst_time, priority_level};
  assign rec_re    = (ctrl.op == OP_SCAN_RD) || (ctrl.op == OP_EMIT_RD);
  assign rec_raddr = idx;
  assign {rd_arr, rd_bur, rd_pri} = rec_rdata;

  assign time_sum  = cur_time + TIME_W'(burst_best);
  assign comp_we   = (ctrl.op == OP_DECIDE) && found;
  assign comp_re   = (ctrl.op == OP_EMIT_RD);
  assign tat       = comp_rdata - TIME_W'(rd_arr);
  assign idx_plus  = CNT_W'(idx) + CNT_W'(1);
  assign emit_load = (ctrl.op == OP_EMIT_OUT) && !(out_valid && !out_ready);

  assign status.last_in     = in_acc && last_process;
  assign status.more        = idx_plus < count;
  assign status.sched_open  = (finished + CNT_W'(found)) != count;
  assign status.out_blocked = out_valid && !out_ready;

  nps_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  nps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_comp_ram (
    .clk   (clk),
    .we    (comp_we),
    .waddr (pick),
    .wdata (time_sum),
    .re    (comp_re),
    .raddr (idx),
    .rdata (comp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      finished  <= '0;
      done      <= '0;
      cur_time  <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (rec_we) begin
            count <= count + CNT_W'(1);
          end
        end
        OP_INIT: begin
          cur_time <= '0;
          finished <= '0;
        end
        OP_SCAN_START: begin
          idx      <= '0;
          found    <= 1'b0;
          best     <= {1'b1, {PRI_W{1'b0}}};
          next_arr <= {1'b1, {ARR_W{1'b0}}};
        end
        OP_SCAN_RD: begin
        end
        OP_SCAN_EVAL: begin
          if (!done[idx]) begin
            if (TIME_W'(rd_arr) <= cur_time) begin
              if ({1'b0, rd_pri} < best) begin
                best       <= {1'b0, rd_pri};
                pick       <= idx;
                burst_best <= rd_bur;
                found      <= 1'b1;
              end
            end else if ({1'b0, rd_arr} < next_arr) begin
              next_arr <= {1'b0, rd_arr};
            end
          end
          idx <= idx + IDX_W'(1);
        end
        OP_DECIDE: begin
          if (found) begin
            cur_time   <= time_sum;
            done[pick] <= 1'b1;
            finished   <= finished + CNT_W'(1);
          end else begin
            cur_time <= TIME_W'(next_arr);
          end
        end
        OP_EMIT_START: begin
          idx <= '0;
        end
        OP_EMIT_RD: begin
        end
        OP_EMIT_OUT: begin
        end
        OP_EMIT_NEXT: begin
          idx <= idx + IDX_W'(1);
        end
        OP_FINISH: begin
          count    <= '0;
          done     <= '0;
          cur_time <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      process_index   <= PIDX_W'(idx);
      completion_time <= comp_rdata;
      turnaround_time <= tat;
      waiting_time    <= tat - TIME_W'(rd_bur);
      last_result     <= (idx_plus == count);
    end
  end

endmodule

// ----- sv/nps_checker.sv -----
// Port-level assertions for the priority scheduler and their bind.
module nps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last_process,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nps_pkg::PIDX_W-1:0]   process_index,
  input logic [nps_pkg::TIME_W-1:0]   completion_time,
  input logic                         last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(completion_time))
    else $error("result dropped or changed while stalled");

  a_close_set: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_process |=> !in_ready)
    else $error("input still open after closing transaction");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> !in_ready)
    else $error("input reopened before last result");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=>
      !out_valid || (process_index == $past(process_index) + 6'd1))
    else $error("results out of index order");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_process    (last_process),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .process_index   (process_index),
  .completion_time (completion_time),
  .last_result     (last_result)
);
